// ----- design/sksl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sksl_pkg;

  // Table geometry
  localparam int TABLE_DEPTH   = 1024;
  localparam int KEY_W         = 32;
  localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
  localparam int COUNT_OUT_W   = 11;

  // Match reduction: first level ORs groups of cells, second level ORs groups
  localparam int MATCH_GROUP   = 32;
  localparam int MATCH_GROUPS  = (TABLE_DEPTH + MATCH_GROUP - 1) / MATCH_GROUP;
  localparam int MATCH_PAD_W   = MATCH_GROUPS * MATCH_GROUP;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  // Request function codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_CHECK  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_DUP  = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic                    func;
    logic signed [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic                   found;
    status_t                status;
    logic [COUNT_OUT_W-1:0] entry_count;
  } out_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic                    cmp_en;
    logic                    shift_en;
    logic signed [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- design/sksl_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One slot of the sorted table. Compares its key against the broadcast key,
// and on insert either keeps its key, takes the left neighbor's key, or takes
// the new key when it is the first slot at or above the insertion point.
module sksl_cell (
  input  wire logic                               clk,
  input  wire sksl_pkg::cell_ctrl_t               ctrl,
  input  wire logic                               slot_valid,
  input  wire logic signed [sksl_pkg::KEY_W-1:0]  left_key,
  input  wire logic                               left_ins,
  output logic signed [sksl_pkg::KEY_W-1:0]       key_r,
  output logic                                    eq_r,
  output logic                                    ins_r
);

  logic signed [sksl_pkg::KEY_W-1:0] key_nxt;

  // shift: slots past the insertion point move one to the right
  always_comb begin
    key_nxt = key_r;
    if (ctrl.shift_en && ins_r) begin
      key_nxt = left_ins ? left_key : ctrl.key;
    end
  end

  // compare flags are captured once per request
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (ctrl.cmp_en) begin
      eq_r  <= slot_valid && (key_r == ctrl.key);
      ins_r <= !slot_valid || (key_r > ctrl.key);
    end
  end

endmodule

`default_nettype wire

// ----- design/sksl_match_tree.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Two-level registered OR over the per-slot match flags.
module sksl_match_tree (
  input  wire logic                             clk,
  input  wire logic [sksl_pkg::TABLE_DEPTH-1:0] eq,
  output logic                                  hit
);

  logic [sksl_pkg::MATCH_PAD_W-1:0]  eq_pad;
  logic [sksl_pkg::MATCH_GROUPS-1:0] grp_r;
  logic                              hit_r;

  assign eq_pad = sksl_pkg::MATCH_PAD_W'(eq);

  // level one: one OR per group of slots
  always_ff @(posedge clk) begin
    for (int g = 0; g < sksl_pkg::MATCH_GROUPS; g++) begin
      grp_r[g] <= |eq_pad[g*sksl_pkg::MATCH_GROUP +: sksl_pkg::MATCH_GROUP];
    end
  end

  // level two: across groups
  always_ff @(posedge clk) begin
    hit_r <= |grp_r;
  end

  assign hit = hit_r;

endmodule

`default_nettype wire

// ----- design/sorted_key_set_lookup.sv -----
`timescale 1ns / 1ps
`default_nettype none

// A request accepted in idle passes through the compare state, the two
// match-tree levels and the update state, which registers the result strobe.
// The block is busy until it is back in idle, so it takes no new request
// while one is in flight. Reset clears the state, the entry count and the
// strobe but not the slots; slot contents are never read above the count.
// The result strobe lasts one cycle and the receiver cannot stall it.
module sorted_key_set_lookup (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire sksl_pkg::in_t  in_req,
  output logic                out_strobe,
  output sksl_pkg::out_t      out_rsp
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_RED1,
    ST_RED2,
    ST_DONE
  } state_t;

  state_t                             state_r, state_nxt;
  logic                               func_r, func_nxt;
  logic signed [sksl_pkg::KEY_W-1:0]  req_key_r, req_key_nxt;
  logic [sksl_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic                               out_strobe_r, out_strobe_nxt;
  sksl_pkg::out_t                     out_rsp_r, out_rsp_nxt;

  sksl_pkg::cell_ctrl_t               ctrl;
  logic                               shift_en;
  logic                               hit;
  logic                               is_full;

  logic signed [sksl_pkg::KEY_W-1:0]  slot_key [sksl_pkg::TABLE_DEPTH];
  logic [sksl_pkg::TABLE_DEPTH-1:0]   slot_eq;
  logic [sksl_pkg::TABLE_DEPTH-1:0]   slot_ins;
  logic [sksl_pkg::TABLE_DEPTH-1:0]   slot_valid;

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_rsp    = out_rsp_r;
  assign is_full    = (count_r >= sksl_pkg::DEPTH_CNT);

  // broadcast to the chain
  assign ctrl.cmp_en   = (state_r == ST_CMP);
  assign ctrl.shift_en = shift_en;
  assign ctrl.key      = req_key_r;

  // slot chain
  for (genvar i = 0; i < sksl_pkg::TABLE_DEPTH; i++) begin : g_slot
    logic signed [sksl_pkg::KEY_W-1:0] left_key;
    logic                              left_ins;

    assign slot_valid[i] = (count_r > sksl_pkg::CNT_W'(i));

    if (i == 0) begin : g_head
      assign left_key = '0;
      assign left_ins = 1'b0;
    end else begin : g_body
      assign left_key = slot_key[i-1];
      assign left_ins = slot_ins[i-1];
    end

    sksl_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .slot_valid (slot_valid[i]),
      .left_key   (left_key),
      .left_ins   (left_ins),
      .key_r      (slot_key[i]),
      .eq_r       (slot_eq[i]),
      .ins_r      (slot_ins[i])
    );
  end

  sksl_match_tree u_tree (
    .clk (clk),
    .eq  (slot_eq),
    .hit (hit)
  );

  // sequencer and result decision
  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    req_key_nxt    = req_key_r;
    count_nxt      = count_r;
    out_strobe_nxt = 1'b0;
    out_rsp_nxt    = out_rsp_r;
    shift_en       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          func_nxt    = in_req.func;
          req_key_nxt = in_req.key;
          state_nxt   = ST_CMP;
        end
      end
      ST_CMP:  state_nxt = ST_RED1;
      ST_RED1: state_nxt = ST_RED2;
      ST_RED2: state_nxt = ST_DONE;
      ST_DONE: begin
        out_rsp_nxt.found  = hit;
        out_rsp_nxt.status = sksl_pkg::STATUS_OK;
        if (func_r == sksl_pkg::FUNC_INSERT) begin
          if (hit) begin
            out_rsp_nxt.status = sksl_pkg::STATUS_DUP;
          end else if (is_full) begin
            out_rsp_nxt.status = sksl_pkg::STATUS_FULL;
          end else begin
            shift_en  = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        out_rsp_nxt.entry_count = sksl_pkg::COUNT_OUT_W'(count_nxt);
        out_strobe_nxt          = 1'b1;
        state_nxt               = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    func_r    <= func_nxt;
    req_key_r <= req_key_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

`ifndef SYNTHESIS
  // a result only follows a request in flight
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a request in flight");

  // count never exceeds the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sksl_pkg::DEPTH_CNT)
    else $error("entry count above table depth");

  // full is reported only when the table really is full
  a_full_only_at_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_rsp.status == sksl_pkg::STATUS_FULL) |->
      count_r == sksl_pkg::DEPTH_CNT)
    else $error("full status with room left");

  // the count holds through an update that makes no shift
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !shift_en) |=> $stable(count_r))
    else $error("entry count changed without an insert");
`endif

endmodule

`default_nettype wire

// ----- verif/sksl_checker.sv -----
`timescale 1ns / 1ps

// Watches the request and result channels of the sorted key set, keeps its
// own ascending copy of the table and checks every result in order.
module sksl_checker (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          busy,
  input  wire sksl_pkg::in_t in_req,
  input  wire logic          out_strobe,
  input  wire sksl_pkg::out_t out_rsp,
  output int                 fail_count,
  output int                 pending,
  output int                 dup_seen,
  output int                 full_seen,
  output int                 hit_seen
);

  // Shadow table: ascending keys, valid below held_count
  logic signed [sksl_pkg::KEY_W-1:0] shadow_keys [sksl_pkg::TABLE_DEPTH];
  int                                held_count;
  sksl_pkg::out_t                    rsp_expect_q [$];

  // First index whose key is not below k
  function automatic int first_not_below(logic signed [sksl_pkg::KEY_W-1:0] k);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = held_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_keys[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Apply one request to the shadow table and work out its result
  task automatic apply_request(input sksl_pkg::in_t req, output sksl_pkg::out_t rsp);
    logic signed [sksl_pkg::KEY_W-1:0] k;
    int pos;
    k = $signed(req.key);
    rsp.found  = 1'b0;
    rsp.status = sksl_pkg::STATUS_OK;
    if (req.func == sksl_pkg::FUNC_CHECK) begin
      // empty table and out of range keys answer not found at once
      if (held_count > 0 && k >= shadow_keys[0] && k <= shadow_keys[held_count-1]) begin
        pos = first_not_below(k);
        rsp.found = (pos < held_count) && (shadow_keys[pos] == k);
      end
    end else begin
      pos = first_not_below(k);
      if (pos < held_count && shadow_keys[pos] == k) begin
        rsp.found  = 1'b1;
        rsp.status = sksl_pkg::STATUS_DUP;
      end else if (held_count >= sksl_pkg::TABLE_DEPTH) begin
        rsp.status = sksl_pkg::STATUS_FULL;
      end else begin
        for (int i = held_count; i > pos; i--) shadow_keys[i] = shadow_keys[i-1];
        shadow_keys[pos] = k;
        held_count++;
      end
    end
    rsp.entry_count = sksl_pkg::COUNT_OUT_W'(held_count);
  endtask

  // Sample both channels at each edge
  always @(posedge clk) begin : watch
    sksl_pkg::out_t want;
    sksl_pkg::out_t got;
    int             errs;
    errs = 0;
    if (!rst_n) begin
      held_count = 0;
      rsp_expect_q.delete();
      fail_count <= 0;
      pending    <= 0;
      dup_seen   <= 0;
      full_seen  <= 0;
      hit_seen   <= 0;
    end else begin
      // accepted request
      if (start && !busy) begin
        apply_request(in_req, want);
        rsp_expect_q.push_back(want);
      end
      // result strobe
      if (out_strobe) begin
        got = out_rsp;
        if (rsp_expect_q.size() == 0) begin
          $display("%0t: unexpected result found=%0b status=%0d count=%0d",
                   $time, got.found, got.status, got.entry_count);
          errs++;
        end else begin
          want = rsp_expect_q.pop_front();
          if (got.found !== want.found) begin
            $display("%0t: found mismatch, expected %0b actual %0b",
                     $time, want.found, got.found);
            errs++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, got.status);
            errs++;
          end
          if (got.entry_count !== want.entry_count) begin
            $display("%0t: entry_count mismatch, expected %0d actual %0d",
                     $time, want.entry_count, got.entry_count);
            errs++;
          end
          if (want.status == sksl_pkg::STATUS_DUP) dup_seen <= dup_seen + 1;
          if (want.status == sksl_pkg::STATUS_FULL) full_seen <= full_seen + 1;
          if (want.status == sksl_pkg::STATUS_OK && want.found) hit_seen <= hit_seen + 1;
        end
      end
      fail_count <= fail_count + errs;
      pending    <= rsp_expect_q.size();
    end
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam logic signed [sksl_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [sksl_pkg::KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  logic           clk   = 1'b0;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  sksl_pkg::in_t  in_req = '0;
  logic           busy;
  logic           out_strobe;
  sksl_pkg::out_t out_rsp;

  int fail_count;
  int pending;
  int dup_seen;
  int full_seen;
  int hit_seen;

  // Stimulus bookkeeping: keys held so far, to steer hits and fill the table
  bit held_set [int];
  int held_pool [$];
  int idle_pct;
  int sent_inserts;
  int sent_checks;
  int drain_wait;

  always #10 clk = ~clk;

  sorted_key_set_lookup dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_rsp   (out_rsp)
  );

  sksl_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_rsp   (out_rsp),
    .fail_count(fail_count),
    .pending   (pending),
    .dup_seen  (dup_seen),
    .full_seen (full_seen),
    .hit_seen  (hit_seen)
  );

  // Issue one request; start stays high across back-to-back requests
  task automatic issue(input logic func, input logic signed [sksl_pkg::KEY_W-1:0] k);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_req.func <= func;
    in_req.key  <= k;
    do @(posedge clk); while (busy);
    if (func == sksl_pkg::FUNC_INSERT) begin
      sent_inserts++;
      if (!held_set.exists(int'(k)) && held_set.num() < sksl_pkg::TABLE_DEPTH) begin
        held_set[int'(k)] = 1'b1;
        held_pool.push_back(int'(k));
      end
    end else begin
      sent_checks++;
    end
  endtask

  // Key mix: held keys, their neighbors, extremes, small values, full random
  function automatic logic signed [sksl_pkg::KEY_W-1:0] pick_key();
    int r;
    int base;
    r = $urandom_range(99);
    if (held_pool.size() == 0 || r < 30) return $urandom;
    base = held_pool[$urandom_range(held_pool.size() - 1)];
    if (r < 60) return base;
    if (r < 80) return ($urandom_range(1) != 0) ? base + 1 : base - 1;
    if (r < 90) begin
      case ($urandom_range(3))
        0: return KEY_MIN;
        1: return KEY_MAX;
        2: return 0;
        default: return -1;
      endcase
    end
    return $signed($urandom_range(63)) - 32;
  endfunction

  function automatic logic signed [sksl_pkg::KEY_W-1:0] fresh_key();
    int k;
    do k = $urandom; while (held_set.exists(k));
    return k;
  endfunction

  task automatic mixed_phase(input int count, input int pct);
    idle_pct = pct;
    repeat (count) issue(logic'($urandom_range(1)), pick_key());
  endtask

  // Table at capacity: new keys dropped, held keys duplicates, checks
  task automatic full_phase(input int count, input int pct);
    int r;
    idle_pct = pct;
    repeat (count) begin
      r = $urandom_range(2);
      if (r == 0) issue(sksl_pkg::FUNC_INSERT, fresh_key());
      else if (r == 1)
        issue(sksl_pkg::FUNC_INSERT, held_pool[$urandom_range(held_pool.size() - 1)]);
      else issue(sksl_pkg::FUNC_CHECK, pick_key());
    end
  endtask

  initial begin
    sent_inserts = 0;
    sent_checks  = 0;
    idle_pct     = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, range rejection, extremes, duplicates
    issue(sksl_pkg::FUNC_CHECK, 0);
    issue(sksl_pkg::FUNC_CHECK, KEY_MIN);
    issue(sksl_pkg::FUNC_INSERT, 0);
    issue(sksl_pkg::FUNC_INSERT, 0);
    issue(sksl_pkg::FUNC_INSERT, 100);
    issue(sksl_pkg::FUNC_CHECK, -5);
    issue(sksl_pkg::FUNC_CHECK, 200);
    issue(sksl_pkg::FUNC_CHECK, 50);
    issue(sksl_pkg::FUNC_CHECK, 100);
    issue(sksl_pkg::FUNC_CHECK, 0);
    issue(sksl_pkg::FUNC_INSERT, KEY_MIN);
    issue(sksl_pkg::FUNC_INSERT, KEY_MAX);
    issue(sksl_pkg::FUNC_INSERT, -1);
    issue(sksl_pkg::FUNC_INSERT, 1);
    issue(sksl_pkg::FUNC_CHECK, KEY_MIN);
    issue(sksl_pkg::FUNC_CHECK, KEY_MAX);
    issue(sksl_pkg::FUNC_CHECK, KEY_MIN + 1);
    issue(sksl_pkg::FUNC_CHECK, KEY_MAX - 1);
    issue(sksl_pkg::FUNC_INSERT, KEY_MAX);
    issue(sksl_pkg::FUNC_INSERT, KEY_MIN);
    issue(sksl_pkg::FUNC_CHECK, -1);
    issue(sksl_pkg::FUNC_CHECK, 1);
    issue(sksl_pkg::FUNC_CHECK, 2);

    // Random mix under different sender gaps
    mixed_phase(150, 0);
    mixed_phase(150, 50);
    mixed_phase(150, 0);
    mixed_phase(150, 19);

    // Fill the table to capacity with new keys
    idle_pct = 19;
    while (held_set.num() < sksl_pkg::TABLE_DEPTH) issue(sksl_pkg::FUNC_INSERT, fresh_key());

    full_phase(100, 50);
    full_phase(100, 0);

    start <= 1'b0;

    // Drain outstanding results
    drain_wait = 0;
    while (pending != 0 && drain_wait < 2000) begin
      @(posedge clk);
      drain_wait++;
    end
    if (pending != 0) begin
      $display("timeout: %0d results still outstanding", pending);
      $display("testbench: FAIL");
      $finish;
    end else begin
      repeat (10) @(posedge clk);
      $display("covered %0d inserts and %0d checks, table filled to %0d entries",
               sent_inserts, sent_checks, sksl_pkg::TABLE_DEPTH);
      $display("results seen: %0d duplicates, %0d table-full drops, %0d check hits",
               dup_seen, full_seen, hit_seen);
      if (fail_count == 0 && pending == 0) begin
        $display("testbench: PASS");
      end else begin
        $display("testbench: FAIL");
      end
      $finish;
    end
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("timeout: run limit reached");
    $display("testbench: FAIL");
    $finish;
  end

endmodule
